// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition that must never be seen
`define ASSERT_NEVER(label, expr) \
  `ASSERT_PROP(label, !(expr))

`endif

// ===== rtl/fvhc_pkg.sv =====
`default_nettype none

package fvhc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DES,
    ST_SQ,
    ST_SUM,
    ST_ITER,
    ST_HEAD,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    ACT_ZERO  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_DRIVE = 2'd2
  } action_e;

  localparam logic REG_POSITION_GAIN = 1'b0;
  localparam logic REG_MAX_SPEED     = 1'b1;

  localparam logic [15:0] GainReset     = 16'd256;
  localparam logic [15:0] MaxSpeedReset = 16'd2000;

  localparam int SqrtSteps = 26;
  localparam int MaxIter   = 32;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic       des_en;
    logic       sq_en;
    logic       sum_en;
    logic       step_en;
    logic [4:0] step_idx;
    logic       head_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } sts_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fvhc_ctrl.sv =====
`default_nettype none

module fvhc_ctrl
  import fvhc_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam int IterEff = (CORDIC_ITERATIONS > MaxIter) ? MaxIter : CORDIC_ITERATIONS;
  localparam int NSteps  = (IterEff > SqrtSteps) ? IterEff : SqrtSteps;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_DES;
      end
      ST_DES: begin
        cmd_o.des_en = 1'b1;
        state_d      = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        if (sts_i.skip) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        step_d       = '0;
        state_d      = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.step_en  = 1'b1;
        cmd_o.step_idx = step_q;
        if (step_q == 5'(NSteps - 1)) begin
          state_d = ST_HEAD;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_HEAD: begin
        cmd_o.head_en = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/fvhc_datapath.sv =====
`default_nettype none

module fvhc_datapath
  import fvhc_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic        [15:0] cfg_wdata_i,
  input  wire logic               speed_valid_i,
  input  wire logic               target_valid_i,
  input  wire logic signed [23:0] error_north_i,
  input  wire logic signed [23:0] error_east_i,
  input  wire logic signed [18:0] target_vel_north_i,
  input  wire logic signed [18:0] target_vel_east_i,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  output action_e                 action_o,
  output logic                    reached_o,
  output logic signed      [15:0] heading_cd_o,
  output logic             [15:0] speed_cmd_o
);

  localparam int IterEff = (CORDIC_ITERATIONS > MaxIter) ? MaxIter : CORDIC_ITERATIONS;

  logic [15:0] gain_q, max_speed_q;
  logic        reached_q;

  logic               spd_q, tgt_q;
  logic signed [23:0] en_q, ee_q;
  logic signed [18:0] vn_q, ve_q;
  logic signed [40:0] pn_q, pe_q;
  logic signed [24:0] dn_q, de_q;
  logic        [49:0] sqn_q, sqe_q;
  logic        [51:0] rad_q;
  logic        [27:0] rem_q;
  logic        [25:0] root_q;
  logic signed [27:0] x_q, y_q;
  logic        [31:0] z_q;
  logic signed [48:0] hp_q;

  action_e            act_q;
  logic signed [15:0] head_q;
  logic        [15:0] spd_cmd_q;

  logic signed [41:0] tn, te;
  logic               zero_vec;
  logic        [27:0] rem_sh, trial;
  logic signed [27:0] xs, ys;
  logic signed [27:0] x0, y0;
  logic        [31:0] z0;
  logic        [26:0] s_rnd;
  logic        [15:0] spd_lim;
  logic signed [48:0] hs;
  logic signed [16:0] cd_raw, cd_wrap;
  action_e            act_d;

  function automatic logic signed [24:0] sat_des(input logic signed [41:0] t);
    logic signed [33:0] v;
    v = 34'(t >>> 8);
    if (v > 34'sd16777215) begin
      return 25'sh0FFFFFF;
    end else if (v < -34'sd16777216) begin
      return 25'sh1000000;
    end
    return 25'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GainReset;
      max_speed_q <= MaxSpeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POSITION_GAIN: gain_q      <= cfg_wdata_i;
        REG_MAX_SPEED:     max_speed_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // desired velocity
  assign tn = (42'(vn_q) <<< 8) + 42'(pn_q) + 42'sd128;
  assign te = (42'(ve_q) <<< 8) + 42'(pe_q) + 42'sd128;

  assign zero_vec   = (dn_q == '0) && (de_q == '0);
  assign sts_o.skip = !spd_q || !tgt_q || zero_vec;

  // sqrt digit step
  assign rem_sh = {rem_q[25:0], rad_q[51:50]};
  assign trial  = {root_q, 2'b01};

  // cordic shifts and pre-rotation
  assign xs = x_q >>> cmd_i.step_idx;
  assign ys = y_q >>> cmd_i.step_idx;

  always_comb begin
    x0 = 28'(dn_q);
    y0 = 28'(de_q);
    z0 = 32'h00000000;
    if (dn_q < 0) begin
      if (de_q >= 0) begin
        x0 = 28'(de_q);
        y0 = -28'(dn_q);
        z0 = 32'h40000000;
      end else begin
        x0 = -28'(de_q);
        y0 = 28'(dn_q);
        z0 = 32'hC0000000;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      spd_q <= speed_valid_i;
      tgt_q <= target_valid_i;
      en_q  <= error_north_i;
      ee_q  <= error_east_i;
      vn_q  <= target_vel_north_i;
      ve_q  <= target_vel_east_i;
    end
    if (cmd_i.mul_en) begin
      pn_q <= en_q * $signed({1'b0, gain_q});
      pe_q <= ee_q * $signed({1'b0, gain_q});
    end
    if (cmd_i.des_en) begin
      dn_q <= sat_des(tn);
      de_q <= sat_des(te);
    end
    if (cmd_i.sq_en) begin
      sqn_q <= dn_q * dn_q;
      sqe_q <= de_q * de_q;
    end
    if (cmd_i.sum_en) begin
      rad_q  <= 52'(sqn_q) + 52'(sqe_q);
      rem_q  <= '0;
      root_q <= '0;
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
    end
    if (cmd_i.step_en) begin
      if (32'(cmd_i.step_idx) < SqrtSteps) begin
        rad_q <= {rad_q[49:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[24:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[24:0], 1'b0};
        end
      end
      if (32'(cmd_i.step_idx) < IterEff) begin
        if (y_q >= 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_lut(cmd_i.step_idx);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_lut(cmd_i.step_idx);
        end
      end
    end
    if (cmd_i.head_en) begin
      hp_q <= $signed(z_q) * $signed(17'd36000);
    end
  end

  // final rounding, clamp and heading wrap
  assign s_rnd   = 27'(root_q) + 27'(rem_q > 28'(root_q));
  assign spd_lim = (s_rnd > 27'(max_speed_q)) ? max_speed_q : s_rnd[15:0];
  assign hs      = hp_q + 49'sd2147483648;
  assign cd_raw  = hs[48:32];

  always_comb begin
    cd_wrap = cd_raw;
    if (cd_raw <= -17'sd18000) begin
      cd_wrap = cd_raw + 17'sd36000;
    end else if (cd_raw > 17'sd18000) begin
      cd_wrap = cd_raw - 17'sd36000;
    end
  end

  always_comb begin
    if (!spd_q) begin
      act_d = ACT_ZERO;
    end else if (!tgt_q || zero_vec) begin
      act_d = ACT_STOP;
    end else begin
      act_d = ACT_DRIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reached_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      unique case (act_d)
        ACT_STOP:  reached_q <= 1'b1;
        ACT_DRIVE: reached_q <= 1'b0;
        default:   reached_q <= reached_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      act_q <= act_d;
      if (act_d == ACT_DRIVE) begin
        head_q    <= cd_wrap[15:0];
        spd_cmd_q <= spd_lim;
      end else begin
        head_q    <= '0;
        spd_cmd_q <= '0;
      end
    end
  end

  assign action_o     = act_q;
  assign reached_o    = reached_q;
  assign heading_cd_o = head_q;
  assign speed_cmd_o  = spd_cmd_q;

endmodule

`default_nettype wire

// ===== rtl/follow_velocity_heading_command_top.sv =====
// an input word passes the capture, multiply, desired-velocity and square states;
//   when driving also the sum state, N = max(min(CORDIC_ITERATIONS, 32), 26) steps of
//   the shared sqrt / cordic iteration loop and the heading state
// a new word is taken only in the idle state, also while a result waits
// reset: position_gain 256, max_speed 2000, reached flag cleared, both channels empty
`default_nettype none

module follow_velocity_heading_command_top
  import fvhc_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // error_north, error_east, target_vel_north, target_vel_east
  input  wire logic [87:0] s_axis_tdata,
  // speed_valid, target_valid
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // reached, heading_cd, speed_cmd
  output logic [39:0]      m_axis_tdata,
  // action
  output logic [1:0]       m_axis_tuser
);

  cmd_t               cmd;
  sts_t               sts;
  action_e            action;
  logic               reached;
  logic signed [15:0] heading_cd;
  logic        [15:0] speed_cmd;
  logic               out_drive;
  logic               heading_ok;

  fvhc_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fvhc_datapath #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .speed_valid_i     (s_axis_tuser[0]),
    .target_valid_i    (s_axis_tuser[1]),
    .error_north_i     ($signed(s_axis_tdata[23:0])),
    .error_east_i      ($signed(s_axis_tdata[47:24])),
    .target_vel_north_i($signed(s_axis_tdata[66:48])),
    .target_vel_east_i ($signed(s_axis_tdata[85:67])),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_o          (action),
    .reached_o         (reached),
    .heading_cd_o      (heading_cd),
    .speed_cmd_o       (speed_cmd)
  );

  assign m_axis_tuser = action;
  assign m_axis_tdata = {7'b0, speed_cmd, heading_cd, reached};

  assign out_drive  = m_axis_tvalid && (action == ACT_DRIVE);
  assign heading_ok = (heading_cd > -16'sd18000) && (heading_cd <= 16'sd18000);

`include "assert_macros.svh"

  `ASSERT_PROP(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `ASSERT_NEVER(a_drive_reached, out_drive && m_axis_tdata[0])
  `ASSERT_NEVER(a_stop_not_reached, m_axis_tvalid && (action == ACT_STOP) && !m_axis_tdata[0])
  `ASSERT_PROP(a_heading_range, out_drive |-> heading_ok)
  `ASSERT_PROP(a_idle_fields_zero, (m_axis_tvalid && !out_drive) |-> (m_axis_tdata[32:1] == 32'd0))

endmodule

`default_nettype wire
